FILE: hw/rtl/postfix_expression_evaluator_defines.svh
// Assertion macros shared by the postfix expression evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define PEE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define PEE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/pee_pkg.sv
// Package with the types, codes and constants of the postfix expression evaluator.
package pee_pkg;

   localparam int DATA_W = 8;
   localparam int STACK_DEPTH_DEFAULT = 128;

   localparam logic [DATA_W-1:0] CHR_ZERO  = 8'd48;
   localparam logic [DATA_W-1:0] CHR_PLUS  = 8'd43;
   localparam logic [DATA_W-1:0] CHR_MINUS = 8'd45;
   localparam logic [DATA_W-1:0] CHR_STAR  = 8'd42;
   localparam logic [DATA_W-1:0] CHR_SLASH = 8'd47;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_DIVZERO   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_UPPER,
      CELL_TAKE_LOWER
   } cell_cmd_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

endpackage

FILE: hw/rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: a shifting stack of cells and its sequencer.
//
// The req channel carries one expression byte per transaction (req_symbol) with
// req_end_of_expression marking the last byte. Operands push (byte - 48); the
// operators + - * / pop two entries and push the 8-bit wrapped result.
// After a transaction marked as the last byte, the rsp channel carries one
// transaction with the final value and a status (ok, underflow, overflow,
// divide by zero); the first error of an expression is the one reported.
// Each byte is captured first and then applied by shifting the row of stack
// cells; a divide with a nonzero divisor first runs the one-bit-per-cycle
// divider. A result appears in the cycle after the final byte's shift step.
// The response sits in an output register, so the next byte is accepted while
// the receiver stalls; only a further last byte waits for that register to empty.
// Synchronous reset empties the stack, clears the error and drops any response.
`include "postfix_expression_evaluator_defines.svh"
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pee_pkg::DATA_W-1:0]        req_symbol,
   input  logic                              req_end_of_expression,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pee_pkg::DATA_W-1:0] rsp_value,
   output logic [1:0]                        rsp_status
);

   localparam int W = pee_pkg::DATA_W;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_type;
   typedef enum logic [1:0] {STK_HOLD, STK_PUSH, STK_TOP_ONLY, STK_COLLAPSE} stack_cmd_type;

   state_type            state_ff, state_in;
   logic [W-1:0]         sym_ff, sym_in;
   logic                 last_ff, last_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   pee_pkg::status_type  err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]  rsp_value_ff, rsp_value_in;
   pee_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic [W-1:0]         cell_q [STACK_DEPTH];
   pee_pkg::cell_cmd_type cell_cmd [STACK_DEPTH];
   stack_cmd_type        stack_cmd;

   pee_pkg::div_req_type div_req;
   logic                 div_busy;
   logic [W-1:0]         div_quotient;

   logic                 is_op, is_div, full, right_zero, div_start, out_blocked, commit;
   logic [W-1:0]         right, left, operand, alu_result, op_result, push_value, top_after;
   logic [2*W-1:0]       product;
   pee_pkg::status_type  err_note, err_next;

   assign is_op = (sym_ff == pee_pkg::CHR_PLUS) || (sym_ff == pee_pkg::CHR_MINUS) ||
                  (sym_ff == pee_pkg::CHR_STAR) || (sym_ff == pee_pkg::CHR_SLASH);
   assign is_div = (sym_ff == pee_pkg::CHR_SLASH);
   assign full = (count_ff == CNT_W'(STACK_DEPTH));
   assign right = (count_ff != '0) ? cell_q[0] : '0;
   assign left = (count_ff >= CNT_W'(2)) ? cell_q[1] : '0;
   assign right_zero = (right == '0);
   assign operand = sym_ff - pee_pkg::CHR_ZERO;
   assign product = {{W{1'b0}}, left} * {{W{1'b0}}, right};

   always_comb begin
      case (sym_ff)
         pee_pkg::CHR_PLUS:  alu_result = left + right;
         pee_pkg::CHR_MINUS: alu_result = left - right;
         pee_pkg::CHR_STAR:  alu_result = product[W-1:0];
         default:            alu_result = '0;
      endcase
   end

   assign op_result = is_div ? (right_zero ? '0 : div_quotient) : alu_result;
   assign push_value = is_op ? op_result : operand;
   assign top_after = is_op ? op_result : (full ? cell_q[0] : operand);

   assign div_start = (state_ff == S_EXEC) && is_div && !right_zero;
   assign div_req.start = div_start;
   assign div_req.dividend = left;
   assign div_req.divisor = right;

   assign out_blocked = last_ff && rsp_valid_ff && rsp_stall;
   assign commit = !out_blocked &&
                   (((state_ff == S_EXEC) && !div_start) || ((state_ff == S_DIV) && !div_busy));

   always_comb begin
      if (is_op) begin
         if (count_ff < CNT_W'(2)) begin
            err_note = pee_pkg::ST_UNDERFLOW;
         end else if (is_div && right_zero) begin
            err_note = pee_pkg::ST_DIVZERO;
         end else begin
            err_note = pee_pkg::ST_OK;
         end
      end else begin
         err_note = full ? pee_pkg::ST_OVERFLOW : pee_pkg::ST_OK;
      end
      err_next = (err_ff != pee_pkg::ST_OK) ? err_ff : err_note;
   end

   always_comb begin
      if (!commit) begin
         stack_cmd = STK_HOLD;
      end else if (is_op) begin
         stack_cmd = (count_ff < CNT_W'(2)) ? STK_TOP_ONLY : STK_COLLAPSE;
      end else begin
         stack_cmd = full ? STK_HOLD : STK_PUSH;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [W-1:0] upper;
      logic [W-1:0] lower;
      if (i == 0) begin : g_top
         assign upper = push_value;
         always_comb begin
            case (stack_cmd)
               STK_HOLD: cell_cmd[i] = pee_pkg::CELL_HOLD;
               default:  cell_cmd[i] = pee_pkg::CELL_TAKE_UPPER;
            endcase
         end
      end else begin : g_below
         assign upper = cell_q[i-1];
         always_comb begin
            case (stack_cmd)
               STK_PUSH:     cell_cmd[i] = pee_pkg::CELL_TAKE_UPPER;
               STK_COLLAPSE: cell_cmd[i] = pee_pkg::CELL_TAKE_LOWER;
               default:      cell_cmd[i] = pee_pkg::CELL_HOLD;
            endcase
         end
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign lower = '0;
      end else begin : g_inner
         assign lower = cell_q[i+1];
      end
      pee_cell u_cell (
         .clock    (clock),
         .cmd      (cell_cmd[i]),
         .upper_in (upper),
         .lower_in (lower),
         .data_out (cell_q[i])
      );
   end

   pee_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      sym_in = sym_ff;
      last_in = last_ff;
      count_in = count_ff;
      err_in = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sym_in = req_symbol;
               last_in = req_end_of_expression;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (div_start) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (commit) begin
         state_in = S_IDLE;
         err_in = err_next;
         if (is_op) begin
            count_in = (count_ff < CNT_W'(2)) ? CNT_W'(1) : count_ff - 1'b1;
         end else if (!full) begin
            count_in = count_ff + 1'b1;
         end
         if (last_ff) begin
            count_in = '0;
            err_in = pee_pkg::ST_OK;
            rsp_valid_in = 1'b1;
            rsp_value_in = top_after;
            rsp_status_in = err_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         err_ff <= pee_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff <= sym_in;
      last_ff <= last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   `PEE_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(STACK_DEPTH))
   `PEE_ASSERT_NEXT(a_end_clears, commit && last_ff,
                    rsp_valid_ff && (count_ff == '0) && (err_ff == pee_pkg::ST_OK))
   `PEE_ASSERT_NEXT(a_div_runs, div_start, (state_ff == S_DIV) && div_busy)
   `PEE_ASSERT_NEXT(a_err_sticky, (err_ff != pee_pkg::ST_OK) && !(commit && last_ff),
                    $stable(err_ff))

endmodule

FILE: hw/rtl/pee_cell.sv
// One stack entry that loads from its upper or lower neighbor or holds.
module pee_cell (
   input  logic                       clock,
   input  pee_pkg::cell_cmd_type      cmd,
   input  logic [pee_pkg::DATA_W-1:0] upper_in,
   input  logic [pee_pkg::DATA_W-1:0] lower_in,
   output logic [pee_pkg::DATA_W-1:0] data_out
);

   logic [pee_pkg::DATA_W-1:0] data_ff;
   logic [pee_pkg::DATA_W-1:0] data_in;

   always_comb begin
      case (cmd)
         pee_pkg::CELL_TAKE_UPPER: data_in = upper_in;
         pee_pkg::CELL_TAKE_LOWER: data_in = lower_in;
         default:                  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

FILE: hw/rtl/pee_divider.sv
// Iterative signed divider that truncates toward zero, one quotient bit per cycle.
module pee_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  pee_pkg::div_req_type       req,
   output logic                       busy,
   output logic [pee_pkg::DATA_W-1:0] quotient
);

   localparam int W = pee_pkg::DATA_W;
   localparam int STEP_W = $clog2(W + 1);

   logic              busy_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [W-1:0]      rem_ff;
   logic [W-1:0]      quo_ff;
   logic [W-1:0]      div_ff;
   logic              neg_ff;

   logic [W-1:0] dividend_mag;
   logic [W-1:0] divisor_mag;
   logic [W-1:0] shifted;
   logic [W:0]   trial;

   assign dividend_mag = req.dividend[W-1] ? W'(~req.dividend + 1'b1) : req.dividend;
   assign divisor_mag  = req.divisor[W-1] ? W'(~req.divisor + 1'b1) : req.divisor;
   assign shifted = {rem_ff[W-2:0], quo_ff[W-1]};
   assign trial = {1'b0, shifted} - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req.start) begin
         busy_ff  <= 1'b1;
         steps_ff <= STEP_W'(W);
         rem_ff   <= '0;
         quo_ff   <= dividend_mag;
         div_ff   <= divisor_mag;
         neg_ff   <= req.dividend[W-1] ^ req.divisor[W-1];
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
         steps_ff <= steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? W'(~quo_ff + 1'b1) : quo_ff;

endmodule

FILE: tb/postfix_result_checker.sv
// Checker that predicts each evaluated expression and compares it with the block's responses.
`timescale 1ns / 100ps
module postfix_result_checker
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [DATA_W-1:0] req_symbol,
   input  logic              req_end_of_expression,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [DATA_W-1:0] rsp_value,
   input  logic [1:0]        rsp_status,
   output int                mismatch_count,
   output int                results_outstanding,
   output int                results_checked,
   output int                faults_reported
);

   typedef struct {
      logic [DATA_W-1:0] value;
      status_type        status;
   } evaluation_type;

   logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
   int                operand_count;
   status_type        expr_error;
   evaluation_type    evaluations_q [$];

   function automatic void note_error(input status_type code);
      if (expr_error == ST_OK) begin
         expr_error = code;
      end
   endfunction

   function automatic void push_operand(input logic [DATA_W-1:0] value);
      if (operand_count >= STACK_DEPTH) begin
         note_error(ST_OVERFLOW);
      end else begin
         operand_mem[operand_count] = value;
         operand_count++;
      end
   endfunction

   function automatic logic [DATA_W-1:0] pop_operand();
      if (operand_count == 0) begin
         note_error(ST_UNDERFLOW);
         return '0;
      end
      operand_count--;
      return operand_mem[operand_count];
   endfunction

   function automatic logic [DATA_W-1:0] apply_operator(input logic [DATA_W-1:0] op,
                                                        input logic [DATA_W-1:0] lhs,
                                                        input logic [DATA_W-1:0] rhs);
      int x;
      int y;
      x = $signed(lhs);
      y = $signed(rhs);
      case (op)
         CHR_PLUS: begin
            return lhs + rhs;
         end
         CHR_MINUS: begin
            return lhs - rhs;
         end
         CHR_STAR: begin
            return DATA_W'(x * y);
         end
         default: begin
            if (y == 0) begin
               note_error(ST_DIVZERO);
               return '0;
            end
            return DATA_W'(x / y);
         end
      endcase
   endfunction

   task automatic evaluate_symbol(input logic [DATA_W-1:0] symbol, input logic last);
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] lhs;
      evaluation_type    outcome;
      if (symbol == CHR_PLUS || symbol == CHR_MINUS || symbol == CHR_STAR ||
          symbol == CHR_SLASH) begin
         rhs = pop_operand();
         lhs = pop_operand();
         push_operand(apply_operator(symbol, lhs, rhs));
      end else begin
         push_operand(symbol - CHR_ZERO);
      end
      if (last) begin
         outcome.value = pop_operand();
         outcome.status = expr_error;
         evaluations_q.push_back(outcome);
         operand_count = 0;
         expr_error = ST_OK;
      end
   endtask

   task automatic check_response();
      evaluation_type wanted;
      if (evaluations_q.size() == 0) begin
         $display("%0t: response value %0d status %0d arrived with none expected",
                  $time, $signed(rsp_value), rsp_status);
         mismatch_count++;
      end else begin
         wanted = evaluations_q.pop_front();
         results_checked++;
         if (wanted.status != ST_OK) begin
            faults_reported++;
         end
         if (rsp_value !== wanted.value) begin
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, $signed(wanted.value), $signed(rsp_value));
            mismatch_count++;
         end
         if (rsp_status !== wanted.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, wanted.status, rsp_status);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         operand_count = 0;
         expr_error = ST_OK;
         evaluations_q.delete();
         mismatch_count = 0;
         results_checked = 0;
         faults_reported = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_response();
         end
         if (req_valid && !req_stall) begin
            evaluate_symbol(req_symbol, req_end_of_expression);
         end
      end
      results_outstanding = evaluations_q.size();
   end

endmodule

FILE: tb/tb.sv
// Testbench top for the postfix expression evaluator: stimulus, response pacing and verdict.
`timescale 1ns / 100ps
module tb;
   import pee_pkg::*;

   localparam int STACK_DEPTH   = STACK_DEPTH_DEFAULT;
   localparam int RANDOM_BYTES  = 350;
   localparam int STALL_LIMIT   = 500;
   localparam int DRAIN_CYCLES  = 30;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_symbol = '0;
   logic              req_end_of_expression = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic [1:0]        rsp_status;

   int mismatch_count;
   int results_outstanding;
   int results_checked;
   int faults_reported;
   int bytes_sent = 0;
   int expressions_sent = 0;
   int quiet_cycles = 0;
   bit req_paced = 1'b1;
   bit rsp_paced = 1'b1;

   postfix_expression_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_symbol            (req_symbol),
      .req_end_of_expression (req_end_of_expression),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_value             (rsp_value),
      .rsp_status            (rsp_status)
   );

   postfix_result_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_symbol            (req_symbol),
      .req_end_of_expression (req_end_of_expression),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_value             (rsp_value),
      .rsp_status            (rsp_status),
      .mismatch_count        (mismatch_count),
      .results_outstanding   (results_outstanding),
      .results_checked       (results_checked),
      .faults_reported       (faults_reported)
   );

   always #5 clock = ~clock;

   task automatic send_symbol(input logic [DATA_W-1:0] symbol, input logic last);
      int gap;
      gap = req_paced ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_symbol <= DATA_W'($urandom);
         req_end_of_expression <= 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_symbol <= symbol;
      req_end_of_expression <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (last) begin
         expressions_sent++;
      end
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_symbol(text[i], i == text.len() - 1);
      end
   endtask

   function automatic logic [DATA_W-1:0] random_operator();
      case ($urandom_range(0, 3))
         0: return CHR_PLUS;
         1: return CHR_MINUS;
         2: return CHR_STAR;
         default: return CHR_SLASH;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_operand();
      logic [DATA_W-1:0] symbol;
      if ($urandom_range(0, 3) != 0) begin
         return CHR_ZERO + DATA_W'($urandom_range(0, 9));
      end
      do begin
         symbol = DATA_W'($urandom);
      end while (symbol == CHR_PLUS || symbol == CHR_MINUS || symbol == CHR_STAR ||
                 symbol == CHR_SLASH);
      return symbol;
   endfunction

   task automatic send_random_expression();
      logic [DATA_W-1:0] symbols_q [$];
      int kind;
      int ops_left;
      int pushes_left;
      int depth;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 6)) symbols_q.push_back(DATA_W'($urandom));
      end else begin
         ops_left = $urandom_range(0, 6);
         pushes_left = ops_left + 1;
         depth = 0;
         while (ops_left + pushes_left > 0) begin
            if (depth >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 1))) begin
               symbols_q.push_back(random_operator());
               ops_left--;
               depth--;
            end else begin
               symbols_q.push_back(random_operand());
               pushes_left--;
               depth++;
            end
         end
         if (kind == 1) begin
            case ($urandom_range(0, 2))
               0: symbols_q.insert($urandom_range(0, symbols_q.size() - 1), random_operator());
               1: if (symbols_q.size() > 1) symbols_q.delete(symbols_q.size() - 1);
               default: symbols_q.push_front(random_operator());
            endcase
         end
      end
      foreach (symbols_q[i]) begin
         send_symbol(symbols_q[i], i == symbols_q.size() - 1);
      end
   endtask

   initial begin
      int pause;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            rsp_paced = ~rsp_paced;
         end
         pause = rsp_paced ? $urandom_range(0, 13) : 0;
         if (pause > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (pause - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   initial begin
      wait (reset == 1'b0);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("95-3*");
      send_text("07-2/");
      send_text("50/");
      send_symbol(8'd176, 1'b0);
      send_text("01-/");
      send_text("+");
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b1);
      send_text("1+50/");

      for (int i = 0; i <= STACK_DEPTH; i++) begin
         send_symbol(CHR_ZERO + DATA_W'($urandom_range(0, 9)), 1'b0);
      end
      send_symbol(CHR_STAR, 1'b1);

      while (bytes_sent < STACK_DEPTH + 27 + RANDOM_BYTES) begin
         if ($urandom_range(0, 7) == 0) begin
            req_paced = ~req_paced;
         end
         send_random_expression();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (results_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d expression bytes in %0d expressions, including a stack fill past %0d.",
               bytes_sent, expressions_sent, STACK_DEPTH);
      $display("Checked %0d results, %0d of them with an error status.",
               results_checked, faults_reported);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
